// ===== src/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants for the cubic spline barrier evaluator
// Fixed-point widths, function codes and the control word that travels
// down the pipeline next to each item.
// ----------------------------------------------------------------------------
package csb_pkg;

  // Fractional bits of the Q8.24 distance format
  localparam int FRAC_BITS = 24;

  // Port widths
  localparam int DIST_W = 32;
  localparam int SUP_W  = 31;
  localparam int RES_W  = 64;

  // Intermediate widths: t, t^2, t^3, D^2, numerator product, its triple
  localparam int T_W   = SUP_W;
  localparam int T2_W  = 2 * T_W;
  localparam int T3_W  = 3 * T_W;
  localparam int F_W   = T3_W + 3;
  localparam int D2_W  = 2 * T3_W;
  localparam int NP_W  = T_W + T3_W + F_W;
  localparam int NP3_W = NP_W + 2;

  // Shift amounts that scale the numerator for each function
  localparam int SHIFT_VALUE = 32;
  localparam int SHIFT_GRAD  = 32 + FRAC_BITS;
  localparam int SHIFT_HESS  = 32 + 2 * FRAC_BITS;

  // Divider operand widths
  localparam int NUM_W = NP3_W + SHIFT_HESS;
  localparam int DEN_W = 3 * T3_W;
  localparam int Q_W   = 64;

  // Limb-split multiplier geometry
  localparam int LIMB_W    = 32;
  localparam int MA_LIMBS  = 6;
  localparam int MB_LIMBS  = 3;
  localparam int MA_W      = MA_LIMBS * LIMB_W;
  localparam int MB_W      = MB_LIMBS * LIMB_W;
  localparam int MP_W      = MA_W + MB_W;
  localparam int ROW_W     = MA_W + LIMB_W;
  localparam int MUL_LAT   = 3;

  // Input-to-strobe latency in cycles
  localparam int PIPE_LAT = 4 * MUL_LAT + Q_W + 5;

  // Saturation limits
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FN_VALUE = 2'd0,
    FN_GRAD  = 2'd1,
    FN_HESS  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KD_ZERO = 2'd0,
    KD_INF  = 2'd1,
    KD_CALC = 2'd2
  } kind_t;

  typedef struct packed {
    func_t func;
    kind_t kind;
  } ctl_t;

endpackage

// ===== src/csb_mul.sv =====
// ----------------------------------------------------------------------------
// csb_mul: three-stage wide unsigned multiplier
// Forms 32x32 partial products, folds them into rows, then adds the rows.
// ----------------------------------------------------------------------------
module csb_mul import csb_pkg::*; (
  input  logic            clk,
  input  logic [MA_W-1:0] a,
  input  logic [MB_W-1:0] b,
  output logic [MP_W-1:0] prod
);

  logic [2*LIMB_W-1:0] pp [MA_LIMBS][MB_LIMBS];
  logic [ROW_W-1:0]    row [MB_LIMBS];
  logic [ROW_W-1:0]    row_next [MB_LIMBS];

  // Register all partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < MA_LIMBS; i++) begin
      for (int j = 0; j < MB_LIMBS; j++) begin
        pp[i][j] <= a[LIMB_W*i +: LIMB_W] * b[LIMB_W*j +: LIMB_W];
      end
    end
  end

  // Fold each row: even and odd limbs never overlap, so one add per row
  always_comb begin
    logic [MA_W-1:0] ev;
    logic [MA_W-1:0] od;
    for (int j = 0; j < MB_LIMBS; j++) begin
      ev = '0;
      od = '0;
      for (int k = 0; k < MA_LIMBS / 2; k++) begin
        ev[2*LIMB_W*k +: 2*LIMB_W] = pp[2*k][j];
        od[2*LIMB_W*k +: 2*LIMB_W] = pp[2*k+1][j];
      end
      row_next[j] = {{LIMB_W{1'b0}}, ev} + {od, {LIMB_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MB_LIMBS; j++) begin
      row[j] <= row_next[j];
    end
  end

  // Add the shifted rows
  always_ff @(posedge clk) begin
    prod <= {{(2*LIMB_W){1'b0}}, row[0]}
          + {{LIMB_W{1'b0}}, row[1], {LIMB_W{1'b0}}}
          + {row[2], {(2*LIMB_W){1'b0}}};
  end

endmodule

// ===== src/csb_div.sv =====
// ----------------------------------------------------------------------------
// csb_div: pipelined restoring divider
// One quotient bit per stage after an overflow check; quotient floors.
// ----------------------------------------------------------------------------
module csb_div import csb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ctl_t             in_ctl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output ctl_t             out_ctl,
  output logic [Q_W-1:0]   quot,
  output logic             over
);

  logic             vld   [Q_W+1];
  ctl_t             ctl   [Q_W+1];
  logic [DEN_W-1:0] rem   [Q_W+1];
  logic [DEN_W-1:0] dvs   [Q_W+1];
  logic [Q_W-1:0]   lo    [Q_W+1];
  logic [Q_W-1:0]   q     [Q_W+1];
  logic             ovr   [Q_W+1];

  logic [DEN_W-1:0] num_hi;

  assign num_hi = DEN_W'(num[NUM_W-1:Q_W]);

  // Entry stage: check for a quotient of 2^64 or more, load the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    ctl[0] <= in_ctl;
    dvs[0] <= den;
    rem[0] <= num_hi;
    lo[0]  <= num[Q_W-1:0];
    q[0]   <= '0;
    ovr[0] <= (num_hi >= den);
  end

  // One quotient bit per stage
  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem[g], lo[g][Q_W-1]};
    assign diff  = trial - {1'b0, dvs[g]};
    assign ge    = (trial >= {1'b0, dvs[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      ctl[g+1] <= ctl[g];
      dvs[g+1] <= dvs[g];
      rem[g+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo[g+1]  <= {lo[g][Q_W-2:0], 1'b0};
      q[g+1]   <= {q[g][Q_W-2:0], ge};
      ovr[g+1] <= ovr[g];
    end
  end

  assign out_valid = vld[Q_W];
  assign out_ctl   = ctl[Q_W];
  assign quot      = q[Q_W];
  assign over      = ovr[Q_W];

endmodule

// ===== src/cubic_spline_barrier_eval_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_spline_barrier_eval_unit: cubic spline contact barrier evaluator
// Returns the barrier value, gradient or hessian for a Q8.24 distance as
// a saturated Q32.32 number, with the exact quotient truncated.
// ----------------------------------------------------------------------------
// The unit takes one item in every cycle and busy stays low. Each item
// passes through four levels of three-stage limb multipliers in series,
// two per level, that form t^3, s^3 and the wide numerator and
// denominator, then a divider that checks for overflow and produces one
// quotient bit in each of 64 stages. Results come in input order and
// cannot be held off, so the receiver must take one on every strobe.
// activation_distance (the support distance) is written through cfg_wr_en/cfg_wr_data;
// the user must write it while no item is in flight, as the unit does not enforce this.
module cubic_spline_barrier_eval_unit import csb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SUP_W-1:0]  cfg_wr_data,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func,
  input  logic [DIST_W-1:0] distance,
  output logic              done,
  output logic [RES_W-1:0]  result,
  output logic              is_infinite,
  output logic              saturated
);

  logic [SUP_W-1:0] support;

  // Hold the support distance
  always_ff @(posedge clk) begin
    if (rst) begin
      support <= SUP_W'(1 << FRAC_BITS);
    end else if (cfg_wr_en) begin
      support <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // ---------------- entry: classify and form t = s - x ----------------
  logic signed [DIST_W:0] x_ext;
  logic signed [DIST_W:0] s_ext;
  logic [DIST_W:0]        t_full;
  ctl_t                   ctl_in;

  assign x_ext  = {distance[DIST_W-1], distance};
  assign s_ext  = {2'b00, support};
  assign t_full = s_ext - x_ext;

  always_comb begin
    ctl_in.func = func_t'(func);
    if (ctl_in.func == FN_VALUE && x_ext <= 0) begin
      ctl_in.kind = KD_INF;
    end else if (ctl_in.func != FN_NONE && x_ext > 0 && x_ext < s_ext) begin
      ctl_in.kind = KD_CALC;
    end else begin
      ctl_in.kind = KD_ZERO;
    end
  end

  logic           v1;
  ctl_t           c1;
  logic [T_W-1:0] t1;
  logic [T_W-1:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    c1 <= ctl_in;
    t1 <= t_full[T_W-1:0];
    s1 <= support;
  end

  // ---------------- multiply A: t^2 and s^2 ----------------
  logic [MP_W-1:0] pa_t, pa_s;
  logic            va [MUL_LAT];
  ctl_t            ca [MUL_LAT];
  logic [T_W-1:0]  ta [MUL_LAT];
  logic [T_W-1:0]  sa [MUL_LAT];

  csb_mul u_mul_at (.clk(clk), .a(MA_W'(t1)), .b(MB_W'(t1)), .prod(pa_t));
  csb_mul u_mul_as (.clk(clk), .a(MA_W'(s1)), .b(MB_W'(s1)), .prod(pa_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) va[i] <= 1'b0;
    end else begin
      va[0] <= v1;
      for (int i = 1; i < MUL_LAT; i++) va[i] <= va[i-1];
    end
    ca[0] <= c1;
    ta[0] <= t1;
    sa[0] <= s1;
    for (int i = 1; i < MUL_LAT; i++) begin
      ca[i] <= ca[i-1];
      ta[i] <= ta[i-1];
      sa[i] <= sa[i-1];
    end
  end

  // ---------------- multiply B: t^3 and s^3 ----------------
  logic [MP_W-1:0] pb_t, pb_s;
  logic            vb  [MUL_LAT];
  ctl_t            cb  [MUL_LAT];
  logic [T_W-1:0]  tb  [MUL_LAT];
  logic [T2_W-1:0] t2b [MUL_LAT];

  csb_mul u_mul_bt (.clk(clk), .a(MA_W'(pa_t[T2_W-1:0])),
                    .b(MB_W'(ta[MUL_LAT-1])), .prod(pb_t));
  csb_mul u_mul_bs (.clk(clk), .a(MA_W'(pa_s[T2_W-1:0])),
                    .b(MB_W'(sa[MUL_LAT-1])), .prod(pb_s));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) vb[i] <= 1'b0;
    end else begin
      vb[0] <= va[MUL_LAT-1];
      for (int i = 1; i < MUL_LAT; i++) vb[i] <= vb[i-1];
    end
    cb[0]  <= ca[MUL_LAT-1];
    tb[0]  <= ta[MUL_LAT-1];
    t2b[0] <= pa_t[T2_W-1:0];
    for (int i = 1; i < MUL_LAT; i++) begin
      cb[i]  <= cb[i-1];
      tb[i]  <= tb[i-1];
      t2b[i] <= t2b[i-1];
    end
  end

  // ---------------- stage C: D, the hessian factor, operand select ----------------
  logic [T3_W-1:0] t3_b, s3_b;
  logic [T3_W+1:0] sum_b;

  assign t3_b  = pb_t[T3_W-1:0];
  assign s3_b  = pb_s[T3_W-1:0];
  assign sum_b = {2'b00, s3_b} + {1'b0, t3_b, 1'b0};

  logic            vc;
  ctl_t            cc;
  logic [T3_W-1:0] dc, s3c, t3c;
  logic [F_W-1:0]  fc;
  logic [T2_W-1:0] amc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb[MUL_LAT-1];
    end
    cc  <= cb[MUL_LAT-1];
    dc  <= s3_b - t3_b;
    s3c <= s3_b;
    t3c <= t3_b;
    fc  <= (cb[MUL_LAT-1].func == FN_HESS) ? {sum_b, 1'b0} : F_W'(1);
    amc <= (cb[MUL_LAT-1].func == FN_GRAD) ? t2b[MUL_LAT-1] : T2_W'(tb[MUL_LAT-1]);
  end

  // ---------------- multiply C: t^k s^3 and D^2 ----------------
  logic [MP_W-1:0] pc_m, pc_d;
  logic            vcd [MUL_LAT];
  ctl_t            ccd [MUL_LAT];
  logic [T3_W-1:0] dcd [MUL_LAT];
  logic [T3_W-1:0] t3cd [MUL_LAT];
  logic [F_W-1:0]  fcd [MUL_LAT];

  csb_mul u_mul_cm (.clk(clk), .a(MA_W'(amc)), .b(MB_W'(s3c)), .prod(pc_m));
  csb_mul u_mul_cd (.clk(clk), .a(MA_W'(dc)),  .b(MB_W'(dc)),  .prod(pc_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) vcd[i] <= 1'b0;
    end else begin
      vcd[0] <= vc;
      for (int i = 1; i < MUL_LAT; i++) vcd[i] <= vcd[i-1];
    end
    ccd[0]  <= cc;
    dcd[0]  <= dc;
    t3cd[0] <= t3c;
    fcd[0]  <= fc;
    for (int i = 1; i < MUL_LAT; i++) begin
      ccd[i]  <= ccd[i-1];
      dcd[i]  <= dcd[i-1];
      t3cd[i] <= t3cd[i-1];
      fcd[i]  <= fcd[i-1];
    end
  end

  // ---------------- multiply D: full numerator product and D^3 ----------------
  logic [MP_W-1:0] pd_n, pd_d;
  logic            vdd [MUL_LAT];
  ctl_t            cdd [MUL_LAT];
  logic [T3_W-1:0] ddd [MUL_LAT];
  logic [T3_W-1:0] t3dd [MUL_LAT];
  logic [D2_W-1:0] d2dd [MUL_LAT];

  csb_mul u_mul_dn (.clk(clk), .a(MA_W'(pc_m[T_W+T3_W+T_W-1:0])),
                    .b(MB_W'(fcd[MUL_LAT-1])), .prod(pd_n));
  csb_mul u_mul_dd (.clk(clk), .a(MA_W'(pc_d[D2_W-1:0])),
                    .b(MB_W'(dcd[MUL_LAT-1])), .prod(pd_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) vdd[i] <= 1'b0;
    end else begin
      vdd[0] <= vcd[MUL_LAT-1];
      for (int i = 1; i < MUL_LAT; i++) vdd[i] <= vdd[i-1];
    end
    cdd[0]  <= ccd[MUL_LAT-1];
    ddd[0]  <= dcd[MUL_LAT-1];
    t3dd[0] <= t3cd[MUL_LAT-1];
    d2dd[0] <= pc_d[D2_W-1:0];
    for (int i = 1; i < MUL_LAT; i++) begin
      cdd[i]  <= cdd[i-1];
      ddd[i]  <= ddd[i-1];
      t3dd[i] <= t3dd[i-1];
      d2dd[i] <= d2dd[i-1];
    end
  end

  // ---------------- stage E: pick numerator and denominator ----------------
  logic [NP_W-1:0]  np_d;
  logic [NP3_W-1:0] np3_d;
  ctl_t             ce_in;

  assign np_d  = pd_n[NP_W-1:0];
  assign np3_d = {2'b00, np_d} + {1'b0, np_d, 1'b0};
  assign ce_in = cdd[MUL_LAT-1];

  logic             ve;
  ctl_t             ce;
  logic [NUM_W-1:0] num_e;
  logic [DEN_W-1:0] den_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vdd[MUL_LAT-1];
    end
    ce <= ce_in;
    case (ce_in.func)
      FN_GRAD: begin
        num_e <= NUM_W'(np3_d) << SHIFT_GRAD;
        den_e <= DEN_W'(d2dd[MUL_LAT-1]);
      end
      FN_HESS: begin
        num_e <= NUM_W'(np3_d) << SHIFT_HESS;
        den_e <= pd_d[DEN_W-1:0];
      end
      default: begin
        num_e <= NUM_W'(t3dd[MUL_LAT-1]) << SHIFT_VALUE;
        den_e <= DEN_W'(ddd[MUL_LAT-1]);
      end
    endcase
  end

  // ---------------- divide ----------------
  logic           vq;
  ctl_t           cq;
  logic [Q_W-1:0] quot;
  logic           over;

  csb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ve),
    .in_ctl    (ce),
    .num       (num_e),
    .den       (den_e),
    .out_valid (vq),
    .out_ctl   (cq),
    .quot      (quot),
    .over      (over)
  );

  // ---------------- output: sign, saturate, strobe ----------------
  logic [RES_W-1:0] result_next;
  logic             is_infinite_next;
  logic             saturated_next;

  always_comb begin
    is_infinite_next = 1'b0;
    saturated_next   = 1'b0;
    result_next      = '0;
    case (cq.kind)
      KD_INF: begin
        result_next      = RES_MAX;
        is_infinite_next = 1'b1;
      end
      KD_CALC: begin
        if (cq.func == FN_GRAD) begin
          if (over || quot > RES_MIN) begin
            result_next    = RES_MIN;
            saturated_next = 1'b1;
          end else begin
            result_next = '0 - quot;
          end
        end else begin
          if (over || quot[Q_W-1]) begin
            result_next    = RES_MAX;
            saturated_next = 1'b1;
          end else begin
            result_next = quot;
          end
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
    is_infinite <= is_infinite_next;
    saturated   <= saturated_next;
    result      <= result_next;
  end

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##PIPE_LAT done)
    else $error("item strobe missing after pipeline latency");

  a_inf_max: assert property (@(posedge clk) disable iff (rst)
    (done && is_infinite) |-> (result == RES_MAX && !saturated))
    else $error("infinite item without full-scale result");

  a_sat_ext: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (result == RES_MAX || result == RES_MIN))
    else $error("saturated item not at a range limit");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for cubic_spline_barrier_eval_unit
// Drives value, gradient and hessian requests over several support distances,
// predicts each result with wide exact arithmetic and checks them in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csb_pkg::*;

  typedef struct {
    logic [RES_W-1:0] result;
    logic             is_infinite;
    logic             saturated;
  } barrier_out_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [SUP_W-1:0]  cfg_wr_data;
  logic              start;
  logic              busy;
  logic [1:0]        func;
  logic [DIST_W-1:0] distance;
  logic              done;
  logic [RES_W-1:0]  result;
  logic              is_infinite;
  logic              saturated;

  logic [SUP_W-1:0]  support;
  barrier_out_t      pending_q[$];
  int                mismatches;
  int                idle_pct;

  cubic_spline_barrier_eval_unit u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy), .func(func), .distance(distance),
    .done(done), .result(result), .is_infinite(is_infinite),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact barrier quantity, truncated to Q32.32 and saturated
  function automatic barrier_out_t barrier_eval(func_t fn, logic [DIST_W-1:0] raw,
                                                logic [SUP_W-1:0] s_in);
    barrier_out_t o;
    logic signed [63:0] x;
    logic [511:0] s, t, t2, t3, s3, d, num, den, q;
    logic over;
    o.result = '0;
    o.is_infinite = 1'b0;
    o.saturated = 1'b0;
    x = {{32{raw[DIST_W-1]}}, raw};
    s = s_in;
    if (fn == FN_VALUE && x <= 0) begin
      o.result = RES_MAX;
      o.is_infinite = 1'b1;
    end else if (fn != FN_NONE && x > 0 && x < $signed({1'b0, s_in})) begin
      t = s - x[31:0];
      t2 = t * t;
      t3 = t2 * t;
      s3 = s * s * s;
      d = s3 - t3;
      case (fn)
        FN_VALUE: begin
          num = t3 << SHIFT_VALUE;
          den = d;
        end
        FN_GRAD: begin
          num = (3 * t2 * s3) << SHIFT_GRAD;
          den = d * d;
        end
        default: begin
          num = (6 * t * s3 * (s3 + 2 * t3)) << SHIFT_HESS;
          den = d * d * d;
        end
      endcase
      q = num / den;
      over = |q[511:64];
      if (fn == FN_GRAD) begin
        if (over || q[63:0] > RES_MIN) begin
          o.result = RES_MIN;
          o.saturated = 1'b1;
        end else begin
          o.result = -q[63:0];
        end
      end else begin
        if (over || q[63:0] > RES_MAX) begin
          o.result = RES_MAX;
          o.saturated = 1'b1;
        end else begin
          o.result = q[63:0];
        end
      end
    end
    return o;
  endfunction

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        barrier_out_t e;
        e = pending_q.pop_front();
        if (e.result !== result || e.is_infinite !== is_infinite ||
            e.saturated !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h inf %b sat %b, got %h inf %b sat %b",
                     e.result, e.is_infinite, e.saturated,
                     result, is_infinite, saturated);
        end
      end
    end
  end

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] fn, logic [DIST_W-1:0] x);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start = 1'b1;
    func = fn;
    distance = x;
    do @(posedge clk); while (busy);
    pending_q.push_back(barrier_eval(func_t'(fn), x, support));
    @(negedge clk);
    start = 1'b0;
  endtask

  // Drain in-flight items, then write the support distance
  task automatic set_support(logic [SUP_W-1:0] s);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = s;
    @(posedge clk);
    support = s;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Edges of the distance range for the value, gradient and hessian selectors, plus one FN_NONE item
  task automatic test_edges();
    logic [DIST_W-1:0] pts[8];
    logic [DIST_W-1:0] s_w;
    s_w = {1'b0, support};
    pts = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, s_w - 32'd1, s_w,
            s_w + 32'd1, 32'hFFFF_FFFF};
    for (int f = 0; f < 3; f++)
      foreach (pts[i]) send_item(f[1:0], pts[i]);
    send_item(FN_NONE, s_w >> 1);
  endtask

  // Random items, mostly inside the support
  task automatic test_random(int n);
    logic [DIST_W-1:0] x;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70 && support > 1)
        x = $urandom_range(support - 1, 1);
      else if ($urandom_range(1))
        x = $urandom_range(8, 0);
      else
        x = $urandom;
      send_item($urandom_range(99) < 5 ? FN_NONE : func_t'($urandom_range(2)), x);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = '0;
    distance = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    support = 31'd16777216;
    mismatches = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_edges();
    test_random(200);
    idle_pct = 84;
    set_support(31'h7FFF_FFFF);
    test_edges();
    test_random(250);
    idle_pct = 0;
    set_support(31'd1);
    test_edges();
    test_random(100);
    set_support(31'd2);
    test_random(100);
    idle_pct = 30;
    set_support(SUP_W'($urandom_range(31'h7FFF_FFFF, 31'd3)));
    test_random(250);
    set_support(31'd300);
    test_random(250);
    // Wait for the pipeline to empty
    while (pending_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
